// ===== hdl/pidaw_pkg.sv =====
// shared types, constants and helpers of the anti-windup pid controller
// used by pidaw_mul, pidaw_div and pid_antiwindup_controller
`default_nettype none

package pidaw_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int UNLOAD_STEP_MAX = 6554;
    localparam int DIV_STEPS       = 47;

    localparam logic signed [63:0] UNLOAD_MAX64 = 64'(UNLOAD_STEP_MAX);
    localparam logic [46:0]        UNLOAD_NUM   = 47'(UNLOAD_STEP_MAX) << FRAC_BITS;

    localparam logic [30:0] DRIVE_LIMIT_RST  = 31'd393216;
    localparam logic [30:0] BAND_FLOOR_RST   = 31'd3277;
    localparam logic [30:0] BAND_RATIO_RST   = 31'd32768;
    localparam logic [30:0] UNWIND_SCALE_RST = 31'd65536;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_INTEG_LIMIT  = 3'd3,
        CFG_DRIVE_LIMIT  = 3'd4,
        CFG_BAND_FLOOR   = 3'd5,
        CFG_BAND_RATIO   = 3'd6,
        CFG_UNWIND_SCALE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic               start;
        logic signed [32:0] a;
        logic signed [47:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [46:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [46:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x > 33'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -33'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        logic signed [47:0] r;
        if (x[48] != x[47])
            r = x[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
        else
            r = x[47:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pidaw_mul.sv =====
// sequential q16.16 multiplier: floor(a * b / 2^16), b taken in 16 bit chunks
// depends on pidaw_pkg
`default_nettype none

module pidaw_mul
    import pidaw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic               busy_reg, done_reg;
    logic [1:0]         cnt_reg;
    logic signed [32:0] a_reg;
    logic signed [47:0] b_reg;
    logic signed [49:0] pp_reg;
    logic signed [80:0] acc_reg;

    logic signed [16:0] chunk;
    logic signed [49:0] pp_next;
    logic signed [80:0] pp_ext, pp_shift;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0: chunk = {1'b0, b_reg[15:0]};
            2'd1: chunk = {1'b0, b_reg[31:16]};
            2'd2: chunk = {b_reg[47], b_reg[47:32]};
            2'd3: chunk = '0;
        endcase
        pp_next = a_reg * chunk;
        pp_ext  = {{31{pp_reg[49]}}, pp_reg};
        // pp_reg holds the partial product of the chunk from the previous cycle
        unique case (cnt_reg)
            2'd0: pp_shift = '0;
            2'd1: pp_shift = pp_ext;
            2'd2: pp_shift = pp_ext <<< 16;
            2'd3: pp_shift = pp_ext <<< 32;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                pp_reg  <= pp_next;
                acc_reg <= acc_reg + pp_shift;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg[79:16];

endmodule

`default_nettype wire

// ===== hdl/pidaw_div.sv =====
// restoring divider, one quotient bit a cycle, unsigned magnitudes
// depends on pidaw_pkg
`default_nettype none

module pidaw_div
    import pidaw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic        busy_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [46:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;

    logic [32:0] trial;
    logic        fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[46]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                // quotient bits shift in where the dividend shifts out
                rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                num_reg <= {num_reg[45:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

`default_nettype wire

// ===== hdl/pid_antiwindup_controller.sv =====
// pid / current-loop pi controller with conditional integration anti-windup
// depends on pidaw_pkg, pidaw_mul and pidaw_div
//
// usage: one request on in_valid/in_ready carries a target and a measurement;
// one result on out_valid/out_ready returns the clamped drive and two flags.
// configuration goes through cfg_wr_en/cfg_addr/cfg_wdata; the user must write
// it only while no request is in flight, the block itself does not enforce it;
// a write takes effect at once. every product goes through one shared 33x17
// multiplier; a step uses 4 to 7 products, and a clamp of the integral or of
// the unload step adds a restoring division each.
// a clear request passes through ST_CLR, which loads its zero drive into the
// output register once that register is free. in_ready is high only between
// requests; the next request can be taken in the cycle after a result is
// loaded. the result sits in an output register; while it still holds an
// earlier result and out_ready is low, a finished step waits and no new
// request is taken until that result has moved on.
// reset clears the integral, the previous error and the last drive, and loads
// the default configuration.
`default_nettype none

module pid_antiwindup_controller
    import pidaw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic               clear,
    input  wire logic signed [31:0] setpoint,
    input  wire logic signed [31:0] measured,
    input  wire logic               freeze_request,
    input  wire logic               unload_rate_lim,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      drive,
    output logic                    saturated,
    output logic                    integ_clamped
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_BAND, ST_P, ST_D, ST_IPRE, ST_DECIDE, ST_UNW,
        ST_UNLCHK, ST_IDEL, ST_LDIV, ST_ACCUM, ST_ITERM, ST_CDIV, ST_ITERM2, ST_FIN
    } state_t;

    state_t state_reg;

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [30:0]        integ_limit_reg, drive_limit_reg, band_floor_reg;
    logic [30:0]        band_ratio_reg, unwind_scale_reg;

    logic signed [47:0] error_sum_reg;
    logic signed [31:0] prev_error_reg;

    logic               pi_reg, frz_reg, lim_reg, neg_reg, iclamp_reg, wait_reg;
    logic signed [31:0] sp_reg, err_reg;
    logic signed [47:0] band_reg, delta_reg;
    logic signed [63:0] p_reg, d_reg, ipre_reg, iterm_reg;

    logic               out_valid_reg, sat_out_reg, iclamp_out_reg;
    logic signed [31:0] drive_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    logic               accept, slot_free, use_mul, use_div;
    logic signed [32:0] sp_abs, err_abs, ig_abs;
    logic signed [31:0] err_in, dsub;
    logic [30:0]        ug;
    logic signed [65:0] upre, y, dl66;
    logic               freeze, take_err, opposite, unloading;
    logic signed [47:0] es_acc, qsigned, band_prod;
    logic signed [63:0] lim64;

    pidaw_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    pidaw_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        accept    = in_valid && in_ready;
        slot_free = !out_valid_reg || out_ready;
        err_in    = sat32(33'(setpoint) - 33'(measured));
        sp_abs    = sp_reg[31] ? -33'(sp_reg) : 33'(sp_reg);
        err_abs   = err_reg[31] ? -33'(err_reg) : 33'(err_reg);
        ig_abs    = integ_gain_reg[31] ? -33'(integ_gain_reg) : 33'(integ_gain_reg);
        dsub      = sat32(33'(err_reg) - 33'(prev_error_reg));
        ug        = (unwind_scale_reg == '0) ? UNWIND_SCALE_RST : unwind_scale_reg;
        dl66      = 66'(signed'({1'b0, drive_limit_reg}));
        lim64     = 64'(signed'({1'b0, integ_limit_reg}));
        upre      = 66'(p_reg) + 66'(ipre_reg) + 66'(d_reg);
        y         = 66'(p_reg) + 66'(iterm_reg) + 66'(d_reg);
        freeze    = frz_reg || (upre > dl66 && err_reg > 0)
                    || (upre < -dl66 && err_reg < 0);
        take_err  = !freeze && (48'(err_abs) <= band_reg);
        opposite  = (error_sum_reg > 0 && err_reg < 0) || (error_sum_reg < 0 && err_reg > 0);
        unloading = (ipre_reg > 0 && mrsp.result < 0) || (ipre_reg < 0 && mrsp.result > 0);
        es_acc    = sat48(49'(error_sum_reg) + 49'(delta_reg));
        qsigned   = neg_reg ? -48'(drsp.quo) : 48'(drsp.quo);
        band_prod = mrsp.result[47:0];

        use_mul = (state_reg == ST_BAND) || (state_reg == ST_P) || (state_reg == ST_D)
                  || (state_reg == ST_IPRE) || (state_reg == ST_UNW)
                  || (state_reg == ST_IDEL) || (state_reg == ST_ITERM)
                  || (state_reg == ST_ITERM2);
        use_div = (state_reg == ST_LDIV) || (state_reg == ST_CDIV);

        mreq.start = use_mul && !wait_reg;
        unique case (state_reg)
            ST_BAND:
            begin
                mreq.a = 33'({1'b0, band_ratio_reg});
                mreq.b = 48'(sp_abs);
            end
            ST_P:
            begin
                mreq.a = 33'(prop_gain_reg);
                mreq.b = 48'(err_reg);
            end
            ST_D:
            begin
                mreq.a = 33'(deriv_gain_reg);
                mreq.b = 48'(dsub);
            end
            ST_UNW:
            begin
                mreq.a = 33'({1'b0, ug});
                mreq.b = 48'(err_reg);
            end
            ST_IDEL:
            begin
                mreq.a = 33'(integ_gain_reg);
                mreq.b = delta_reg;
            end
            default:
            begin
                mreq.a = 33'(integ_gain_reg);
                mreq.b = error_sum_reg;
            end
        endcase

        dreq.start = use_div && !wait_reg;
        dreq.num   = (state_reg == ST_LDIV) ? UNLOAD_NUM : {integ_limit_reg, 16'b0};
        dreq.den   = ig_abs[31:0];
        in_ready   = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            integ_limit_reg  <= '0;
            drive_limit_reg  <= DRIVE_LIMIT_RST;
            band_floor_reg   <= BAND_FLOOR_RST;
            band_ratio_reg   <= BAND_RATIO_RST;
            unwind_scale_reg <= UNWIND_SCALE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg_wdata;
                CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_wdata;
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_wdata;
                CFG_INTEG_LIMIT:  integ_limit_reg  <= cfg_wdata[30:0];
                CFG_DRIVE_LIMIT:  drive_limit_reg  <= cfg_wdata[30:0];
                CFG_BAND_FLOOR:   band_floor_reg   <= cfg_wdata[30:0];
                CFG_BAND_RATIO:   band_ratio_reg   <= cfg_wdata[30:0];
                CFG_UNWIND_SCALE: unwind_scale_reg <= cfg_wdata[30:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wait_reg       <= 1'b0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= '0;
            sat_out_reg    <= 1'b0;
            iclamp_out_reg <= 1'b0;
        end
        else
        begin
            // the loading states set out_valid_reg themselves
            if (out_valid_reg && out_ready && state_reg != ST_CLR && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;
            if (mreq.start || dreq.start)
                wait_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pi_reg     <= mode;
                        frz_reg    <= freeze_request;
                        lim_reg    <= unload_rate_lim;
                        sp_reg     <= setpoint;
                        err_reg    <= err_in;
                        iclamp_reg <= 1'b0;
                        if (clear)
                        begin
                            error_sum_reg  <= '0;
                            prev_error_reg <= '0;
                            state_reg      <= ST_CLR;
                        end
                        else
                            state_reg <= ST_BAND;
                    end
                end
                ST_CLR:
                begin
                    if (slot_free)
                    begin
                        drive_reg      <= '0;
                        sat_out_reg    <= 1'b0;
                        iclamp_out_reg <= 1'b0;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_BAND:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        band_reg  <= (band_prod < 48'(band_floor_reg))
                                     ? 48'(band_floor_reg) : band_prod;
                        state_reg <= ST_P;
                    end
                end
                ST_P:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg <= 1'b0;
                        p_reg    <= mrsp.result;
                        d_reg    <= '0;
                        // no derivative term in the pi mode
                        state_reg <= pi_reg ? ST_IPRE : ST_D;
                    end
                end
                ST_D:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        d_reg     <= mrsp.result;
                        state_reg <= ST_IPRE;
                    end
                end
                ST_IPRE:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        ipre_reg  <= mrsp.result;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (take_err)
                    begin
                        delta_reg <= 48'(err_reg);
                        state_reg <= ST_UNLCHK;
                    end
                    else if (opposite)
                        state_reg <= ST_UNW;
                    else
                    begin
                        delta_reg <= '0;
                        state_reg <= ST_UNLCHK;
                    end
                end
                ST_UNW:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        delta_reg <= mrsp.result[47:0];
                        state_reg <= ST_UNLCHK;
                    end
                end
                ST_UNLCHK:
                begin
                    if (pi_reg && lim_reg && delta_reg != 0 && UNLOAD_STEP_MAX > 0
                        && integ_gain_reg != 0 && ipre_reg != 0)
                        state_reg <= ST_IDEL;
                    else
                        state_reg <= ST_ACCUM;
                end
                ST_IDEL:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg <= 1'b0;
                        if (unloading && mrsp.result > UNLOAD_MAX64)
                        begin
                            neg_reg   <= integ_gain_reg[31];
                            state_reg <= ST_LDIV;
                        end
                        else if (unloading && mrsp.result < -UNLOAD_MAX64)
                        begin
                            neg_reg   <= !integ_gain_reg[31];
                            state_reg <= ST_LDIV;
                        end
                        else
                            state_reg <= ST_ACCUM;
                    end
                end
                ST_LDIV:
                begin
                    if (drsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        delta_reg <= qsigned;
                        state_reg <= ST_ACCUM;
                    end
                end
                ST_ACCUM:
                begin
                    error_sum_reg <= es_acc;
                    state_reg     <= ST_ITERM;
                end
                ST_ITERM:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        iterm_reg <= mrsp.result;
                        // a zero gain gives a zero term, so a clamp implies a divisor
                        if (mrsp.result > lim64)
                        begin
                            iclamp_reg <= 1'b1;
                            neg_reg    <= integ_gain_reg[31];
                            state_reg  <= ST_CDIV;
                        end
                        else if (mrsp.result < -lim64)
                        begin
                            iclamp_reg <= 1'b1;
                            neg_reg    <= !integ_gain_reg[31];
                            state_reg  <= ST_CDIV;
                        end
                        else
                            state_reg <= ST_FIN;
                    end
                end
                ST_CDIV:
                begin
                    if (drsp.done)
                    begin
                        wait_reg      <= 1'b0;
                        error_sum_reg <= qsigned;
                        state_reg     <= ST_ITERM2;
                    end
                end
                ST_ITERM2:
                begin
                    if (mrsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        iterm_reg <= mrsp.result;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (slot_free)
                    begin
                        if (y > dl66)
                        begin
                            drive_reg   <= 32'({1'b0, drive_limit_reg});
                            sat_out_reg <= 1'b1;
                        end
                        else if (y < -dl66)
                        begin
                            drive_reg   <= -32'({1'b0, drive_limit_reg});
                            sat_out_reg <= 1'b1;
                        end
                        else
                        begin
                            drive_reg   <= y[31:0];
                            sat_out_reg <= 1'b0;
                        end
                        iclamp_out_reg <= iclamp_reg;
                        prev_error_reg <= err_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign saturated     = sat_out_reg;
    assign integ_clamped = iclamp_out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while a step is still running");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mrsp.busy && drsp.busy))
        else $error("multiplier and divider busy together");

    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive <= $signed({1'b0, drive_limit_reg})
                       && drive >= -$signed({1'b0, drive_limit_reg})))
        else $error("drive beyond its limit");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (33'(drive) == 33'({1'b0, drive_limit_reg})
                                      || 33'(drive) == -33'({1'b0, drive_limit_reg})))
        else $error("saturated flag without drive at its limit");

    a_clear_zeroes_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && clear) |=> (error_sum_reg == 0 && prev_error_reg == 0))
        else $error("clear did not reset the integral state");

endmodule

`default_nettype wire
